@@ rtl/core/plg_pkg.sv @@
// ----------------------------------------------------------------------------
// plg_pkg
// Shared types, constants and helper functions for the Playfair digram cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plg_pkg;

  localparam int SQ_DIM    = 5;
  localparam int LAST_POS  = SQ_DIM - 1;
  localparam int LETTER_W  = 5;
  localparam int ROW_W     = SQ_DIM * LETTER_W;
  localparam int CELLS     = SQ_DIM * SQ_DIM;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W     = $clog2(SQ_DIM);
  localparam int AXIS_W    = 16;

  localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
  localparam logic [LETTER_W-1:0] CODE_J = 5'd9;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef letter_t [SQ_DIM-1:0] row_t;
  typedef row_t [SQ_DIM-1:0]    square_t;
  typedef logic [CELLS-1:0]     hit_t;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_t;

  // Square after reset: a b c d e / f g h i k / l m n o p / q r s t u / v w x y z
  localparam logic [ROW_W-1:0] ROW_RESET [SQ_DIM] = '{
    25'd4294688, 25'd10755269, 25'd16201099, 25'd21613104, 25'd27025109
  };

  typedef struct packed {
    op_t     op;
    letter_t first_letter;
    letter_t second_letter;
  } digram_t;

  typedef struct packed {
    op_t  op;
    hit_t hit1;
    hit_t hit2;
  } match_t;

  typedef struct packed {
    op_t  op;
    logic found;
    pos_t r1;
    pos_t c1;
    pos_t r2;
    pos_t c2;
  } locate_t;

  typedef struct packed {
    letter_t first_out;
    letter_t second_out;
    logic    not_found;
  } result_t;

  // Lowest set bit of a five-wide vector, zero when none.
  function automatic pos_t first_set(input logic [SQ_DIM-1:0] v);
    pos_t idx;
    idx = '0;
    for (int i = SQ_DIM - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = pos_t'(i);
      end
    end
    return idx;
  endfunction

  // Move one place forward (encrypt) or back (decrypt), wrapping.
  function automatic pos_t step_pos(input pos_t p, input op_t op);
    pos_t q;
    case (op)
      OP_ENCRYPT: q = (p == pos_t'(LAST_POS)) ? '0 : p + pos_t'(1);
      OP_DECRYPT: q = (p == '0) ? pos_t'(LAST_POS) : p - pos_t'(1);
      default:    q = p;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/plg_key_square.sv @@
// ----------------------------------------------------------------------------
// plg_key_square
// Five row registers of the 5x5 key square, written through the config port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plg_key_square
  import plg_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ROW_W-1:0]     cfg_data,
  output square_t                   square
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < SQ_DIM; r++) begin
        square[r] <= row_t'(ROW_RESET[r]);
      end
    end else if (cfg_we) begin
      for (int r = 0; r < SQ_DIM; r++) begin
        if (cfg_index == CFG_IDX_W'(r)) begin
          square[r] <= row_t'(cfg_data);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/plg_match.sv @@
// ----------------------------------------------------------------------------
// plg_match
// Stage 1: compare both letters against every cell of the key square.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plg_match
  import plg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire square_t square,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire digram_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output match_t       out_data
);

  letter_t a_key;
  letter_t b_key;
  hit_t    hit1;
  hit_t    hit2;

  // Look up j as i
  assign a_key = (in_data.first_letter == CODE_J) ? CODE_I : in_data.first_letter;
  assign b_key = (in_data.second_letter == CODE_J) ? CODE_I : in_data.second_letter;

  always_comb begin
    for (int r = 0; r < SQ_DIM; r++) begin
      for (int c = 0; c < SQ_DIM; c++) begin
        hit1[r*SQ_DIM + c] = (square[r][c] == a_key);
        hit2[r*SQ_DIM + c] = (square[r][c] == b_key);
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.op   <= in_data.op;
      out_data.hit1 <= hit1;
      out_data.hit2 <= hit2;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/plg_locate.sv @@
// ----------------------------------------------------------------------------
// plg_locate
// Stage 2: reduce match vectors to the first row and column in row-major order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plg_locate
  import plg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire match_t  in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output locate_t      out_data
);

  logic [SQ_DIM-1:0] row_any1;
  logic [SQ_DIM-1:0] row_any2;
  logic [SQ_DIM-1:0] row_sel1;
  logic [SQ_DIM-1:0] row_sel2;
  pos_t              r1;
  pos_t              r2;
  pos_t              c1;
  pos_t              c2;
  logic              found;

  always_comb begin
    for (int r = 0; r < SQ_DIM; r++) begin
      row_any1[r] = |in_data.hit1[r*SQ_DIM +: SQ_DIM];
      row_any2[r] = |in_data.hit2[r*SQ_DIM +: SQ_DIM];
    end
    r1 = first_set(row_any1);
    r2 = first_set(row_any2);
    row_sel1 = '0;
    row_sel2 = '0;
    for (int r = 0; r < SQ_DIM; r++) begin
      if (r1 == pos_t'(r)) begin
        row_sel1 = in_data.hit1[r*SQ_DIM +: SQ_DIM];
      end
      if (r2 == pos_t'(r)) begin
        row_sel2 = in_data.hit2[r*SQ_DIM +: SQ_DIM];
      end
    end
    c1 = first_set(row_sel1);
    c2 = first_set(row_sel2);
    found = (|row_any1) && (|row_any2);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.op    <= in_data.op;
      out_data.found <= found;
      out_data.r1    <= r1;
      out_data.c1    <= c1;
      out_data.r2    <= r2;
      out_data.c2    <= c2;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/plg_xform.sv @@
// ----------------------------------------------------------------------------
// plg_xform
// Stage 3: apply the row, column or rectangle rule and read the output cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plg_xform
  import plg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire square_t square,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire locate_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  pos_t    nr1;
  pos_t    nc1;
  pos_t    nr2;
  pos_t    nc2;
  result_t res;

  always_comb begin
    if (in_data.r1 == in_data.r2) begin
      nr1 = in_data.r1;
      nr2 = in_data.r2;
      nc1 = step_pos(in_data.c1, in_data.op);
      nc2 = step_pos(in_data.c2, in_data.op);
    end else if (in_data.c1 == in_data.c2) begin
      nr1 = step_pos(in_data.r1, in_data.op);
      nr2 = step_pos(in_data.r2, in_data.op);
      nc1 = in_data.c1;
      nc2 = in_data.c2;
    end else begin
      nr1 = in_data.r1;
      nr2 = in_data.r2;
      nc1 = in_data.c2;
      nc2 = in_data.c1;
    end
  end

  always_comb begin
    res = '0;
    if (!in_data.found) begin
      res.not_found = 1'b1;
    end else begin
      for (int r = 0; r < SQ_DIM; r++) begin
        for (int c = 0; c < SQ_DIM; c++) begin
          if (nr1 == pos_t'(r) && nc1 == pos_t'(c)) begin
            res.first_out = square[r][c];
          end
          if (nr2 == pos_t'(r) && nc2 == pos_t'(c)) begin
            res.second_out = square[r][c];
          end
        end
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/playfair_digram_cipher.sv @@
// ----------------------------------------------------------------------------
// playfair_digram_cipher
// Streaming Playfair digram encrypt/decrypt under a configurable key square.
// ----------------------------------------------------------------------------
// One digram enters per cycle while the output is not stalled, and its result
// leaves from the output register of the third stage; throughput is one digram
// per clock with no gaps while m_axis_tready stays high. The three stages are
// cell compare, first-match row/column location, and rule selection with the
// cell read. Stalls on the output back up through the stage valid bits without
// loss. Rewrite the key square rows only while no digram is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module playfair_digram_cipher
  import plg_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ROW_W-1:0]     cfg_data,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // [0] opcode, [5:1] first_letter, [10:6] second_letter, [15:11] zero
  input  wire logic [AXIS_W-1:0]    s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [4:0] first_out, [9:5] second_out, [10] not_found, [15:11] zero
  output logic [AXIS_W-1:0]         m_axis_tdata
);

  square_t square;
  digram_t din;
  match_t  s1_data;
  locate_t s2_data;
  result_t s3_data;
  logic    s1_valid;
  logic    s1_ready;
  logic    s2_valid;
  logic    s2_ready;

  assign din.op            = op_t'(s_axis_tdata[0]);
  assign din.first_letter  = s_axis_tdata[5:1];
  assign din.second_letter = s_axis_tdata[10:6];

  plg_key_square u_square (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .square    (square)
  );

  plg_match u_match (
    .clk       (clk),
    .rst       (rst),
    .square    (square),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (din),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  plg_locate u_locate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  plg_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .square    (square),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (s3_data)
  );

  assign m_axis_tdata = {5'b0, s3_data.not_found, s3_data.second_out, s3_data.first_out};

endmodule

`default_nettype wire

@@ rtl/core/plg_checker.sv @@
// ----------------------------------------------------------------------------
// plg_checker
// Port-level checks on the cipher top level, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plg_checker
  import plg_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_axis_tready,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [AXIS_W-1:0] m_axis_tdata
);

  // Output stalled: hold the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[9:0] == 10'd0)
    else $error("letters not zero on not_found");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:11] == 5'd0)
    else $error("padding bits set");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_empty_after_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind playfair_digram_cipher plg_checker u_plg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ sim/playfair_digram_cipher_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digram_cipher_tb
// Self-checking bench for the streaming Playfair digram cipher.
// ----------------------------------------------------------------------------
// Loads a series of key squares: the reset square, shuffled alphabets, squares
// with repeated and out-of-alphabet codes, and the all-zero and all-one
// extremes. Under each it sends directed and biased random digrams, predicts
// every transformed digram in the bench and compares each output transfer
// field by field. Both stream sides idle at random, with one long output
// hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------

module playfair_digram_cipher_tb;
  import plg_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_LEN    = 80;

  typedef enum int {
    RULE_ROW,
    RULE_COLUMN,
    RULE_RECT,
    RULE_MISSING
  } rule_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [0] opcode, [5:1] first_letter, [10:6] second_letter, [15:11] zero
  logic [AXIS_W-1:0]    s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [4:0] first_out, [9:5] second_out, [10] not_found, [15:11] zero
  logic [AXIS_W-1:0]    m_axis_tdata;

  playfair_digram_cipher dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [ROW_W-1:0] key_rows [SQ_DIM];
  digram_t          digram_q [$];
  result_t          cipher_out_q [$];

  int     error_count = 0;
  int     accepted_in = 0;
  int     results_seen = 0;
  int     square_count = 1;
  int     rule_count [4] = '{0, 0, 0, 0};
  int     idle_cycles = 0;
  int     send_gap = 0;
  int     rx_left = 0;
  bit     burst_mode = 1'b0;
  bit     long_hold_done = 1'b0;
  bit     in_fire = 1'b0;
  digram_t next_digram;
  digram_t seen_digram;
  result_t want;
  rule_t   seen_rule;

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------
  function automatic letter_t square_cell(input int r, input int c);
    return key_rows[r][LETTER_W*c +: LETTER_W];
  endfunction

  // First hit in row-major order; j is looked up as i.
  function automatic bit find_letter(input letter_t code, output int r, output int c);
    letter_t key;
    bit      hit;
    key = (code == CODE_J) ? CODE_I : code;
    hit = 1'b0;
    r = 0;
    c = 0;
    for (int i = CELLS - 1; i >= 0; i--) begin
      if (square_cell(i / SQ_DIM, i % SQ_DIM) == key) begin
        hit = 1'b1;
        r = i / SQ_DIM;
        c = i % SQ_DIM;
      end
    end
    return hit;
  endfunction

  function automatic result_t cipher_digram(input digram_t d, output rule_t rule);
    result_t res;
    int      r1, c1, r2, c2, step;
    bit      hit1, hit2;
    step = (d.op == OP_DECRYPT) ? LAST_POS : 1;
    res = '0;
    hit1 = find_letter(d.first_letter, r1, c1);
    hit2 = find_letter(d.second_letter, r2, c2);
    if (!hit1 || !hit2) begin
      res.not_found = 1'b1;
      rule = RULE_MISSING;
    end else if (r1 == r2) begin
      res.first_out  = square_cell(r1, (c1 + step) % SQ_DIM);
      res.second_out = square_cell(r2, (c2 + step) % SQ_DIM);
      rule = RULE_ROW;
    end else if (c1 == c2) begin
      res.first_out  = square_cell((r1 + step) % SQ_DIM, c1);
      res.second_out = square_cell((r2 + step) % SQ_DIM, c2);
      rule = RULE_COLUMN;
    end else begin
      res.first_out  = square_cell(r1, c2);
      res.second_out = square_cell(r2, c1);
      rule = RULE_RECT;
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch at result %0d: %s got %0d, expected %0d",
             results_seen, what, got, exp_val);
    error_count++;
  endtask

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic int draw_gap();
    int p;
    p = $urandom_range(0, 99);
    if (burst_mode || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic letter_t rand_letter(input int odd_pct);
    if ($urandom_range(0, 99) < odd_pct) return letter_t'($urandom_range(26, 31));
    return letter_t'($urandom_range(0, 25));
  endfunction

  task automatic add_digram(input op_t op, input int a, input int b);
    digram_t d;
    d.op = op;
    d.first_letter = letter_t'(a);
    d.second_letter = letter_t'(b);
    digram_q.push_back(d);
  endtask

  // Bias toward the row and column rules by drawing letters from the square.
  task automatic queue_random(input int n, input int odd_pct);
    int   pick, r1, r2, c1, c2;
    op_t  op;
    for (int k = 0; k < n; k++) begin
      op = op_t'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      r1 = $urandom_range(0, LAST_POS);
      r2 = $urandom_range(0, LAST_POS);
      c1 = $urandom_range(0, LAST_POS);
      c2 = $urandom_range(0, LAST_POS);
      if (pick < 35) begin
        add_digram(op, square_cell(r1, c1), square_cell(r1, c2));
      end else if (pick < 65) begin
        add_digram(op, square_cell(r1, c1), square_cell(r2, c1));
      end else if (pick < 85) begin
        add_digram(op, square_cell(r1, c1), square_cell(r2, c2));
      end else begin
        add_digram(op, rand_letter(odd_pct), rand_letter(odd_pct));
      end
    end
  endtask

  task automatic write_row(input int idx, input logic [ROW_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= value;
    if (idx < SQ_DIM) key_rows[idx] = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_square(input letter_t cells [CELLS]);
    logic [ROW_W-1:0] row;
    for (int r = 0; r < SQ_DIM; r++) begin
      row = '0;
      for (int c = 0; c < SQ_DIM; c++) row[LETTER_W*c +: LETTER_W] = cells[r*SQ_DIM + c];
      write_row(r, row);
    end
    square_count++;
  endtask

  task automatic load_shuffled_square();
    letter_t pool [CELLS];
    letter_t t;
    int      k, j;
    k = 0;
    for (int code = 0; code < 26; code++) begin
      if (code != int'(CODE_J)) begin
        pool[k] = letter_t'(code);
        k++;
      end
    end
    for (int i = CELLS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    load_square(pool);
  endtask

  // Repeated letters, gaps in the alphabet and codes above z.
  task automatic load_rough_square();
    letter_t pool [CELLS];
    for (int i = 0; i < CELLS; i++) pool[i] = rand_letter(30);
    load_square(pool);
  endtask

  task automatic load_flat_square(input letter_t code);
    letter_t pool [CELLS];
    for (int i = 0; i < CELLS; i++) pool[i] = code;
    load_square(pool);
  endtask

  task automatic drain();
    while (digram_q.size() != 0 || s_axis_tvalid || cipher_out_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Driver: input stream, changes at the falling edge
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (digram_q.size() != 0) begin
        next_digram = digram_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= AXIS_W'({next_digram.second_letter, next_digram.first_letter,
                                 next_digram.op});
        send_gap = draw_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: output backpressure, with one long hold-off
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && accepted_in >= HOLD_AT) begin
      long_hold_done = 1'b1;
      m_axis_tready <= 1'b0;
      rx_left = HOLD_LEN;
    end else if (rx_left > 0) begin
      rx_left--;
    end else if (draw_gap() == 0) begin
      m_axis_tready <= 1'b1;
      rx_left = $urandom_range(1, 6);
    end else begin
      m_axis_tready <= 1'b0;
      rx_left = draw_gap();
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: predicts on input transfers, checks output transfers
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        seen_digram.op = op_t'(s_axis_tdata[0]);
        seen_digram.first_letter = s_axis_tdata[5:1];
        seen_digram.second_letter = s_axis_tdata[10:6];
        cipher_out_q.push_back(cipher_digram(seen_digram, seen_rule));
        rule_count[seen_rule]++;
        accepted_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_out_q.size() == 0) begin
          flag_mismatch("unexpected transfer", m_axis_tdata, 0);
        end else begin
          want = cipher_out_q.pop_front();
          if (m_axis_tdata[4:0] != want.first_out)
            flag_mismatch("first_out", m_axis_tdata[4:0], want.first_out);
          if (m_axis_tdata[9:5] != want.second_out)
            flag_mismatch("second_out", m_axis_tdata[9:5], want.second_out);
          if (m_axis_tdata[10] != want.not_found)
            flag_mismatch("not_found", m_axis_tdata[10], want.not_found);
          if (m_axis_tdata[AXIS_W-1:11] != '0)
            flag_mismatch("pad bits", m_axis_tdata[AXIS_W-1:11], 0);
        end
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < SQ_DIM; i++) key_rows[i] = ROW_RESET[i];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset square: a b c d e / f g h i k / l m n o p / q r s t u / v w x y z
    add_digram(OP_ENCRYPT, 0, 1);
    add_digram(OP_DECRYPT, 0, 1);
    add_digram(OP_ENCRYPT, 4, 0);
    add_digram(OP_DECRYPT, 0, 4);
    add_digram(OP_ENCRYPT, 0, 21);
    add_digram(OP_DECRYPT, 0, 5);
    add_digram(OP_ENCRYPT, 0, 25);
    add_digram(OP_DECRYPT, 25, 0);
    add_digram(OP_ENCRYPT, 9, 10);
    add_digram(OP_DECRYPT, 9, 8);
    add_digram(OP_ENCRYPT, 9, 9);
    add_digram(OP_ENCRYPT, 15, 15);
    add_digram(OP_DECRYPT, 15, 15);
    add_digram(OP_ENCRYPT, 0, 0);
    add_digram(OP_DECRYPT, 25, 25);
    add_digram(OP_ENCRYPT, 25, 0);
    add_digram(OP_DECRYPT, 0, 25);
    add_digram(OP_ENCRYPT, 26, 0);
    add_digram(OP_DECRYPT, 0, 31);
    add_digram(OP_ENCRYPT, 31, 31);
    queue_random(150, 5);
    drain();

    // shuffled square, first without idling, then with
    load_shuffled_square();
    burst_mode = 1'b1;
    queue_random(100, 5);
    drain();
    burst_mode = 1'b0;
    queue_random(100, 5);
    drain();

    // repeats and codes above z; unused register indexes must be ignored
    load_rough_square();
    for (int i = SQ_DIM; i < (1 << CFG_IDX_W); i++) write_row(i, ROW_W'($urandom));
    queue_random(150, 20);
    drain();

    load_flat_square('0);
    queue_random(50, 5);
    drain();

    load_flat_square('1);
    queue_random(50, 50);
    drain();

    // sender pauses for a full drain halfway through
    load_shuffled_square();
    queue_random(120, 5);
    drain();
    queue_random(120, 5);
    drain();

    repeat (10) @(posedge clk);
    if (cipher_out_q.size() != 0)
      flag_mismatch("results missing", 0, cipher_out_q.size());
    $display("summary: %0d digrams under %0d key squares, %0d results checked",
             accepted_in, square_count, results_seen);
    $display("summary: row %0d, column %0d, rectangle %0d, missing letter %0d",
             rule_count[RULE_ROW], rule_count[RULE_COLUMN], rule_count[RULE_RECT],
             rule_count[RULE_MISSING]);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
